>>> rtl/raid6xc_pkg.sv
// raid6xc_pkg: shared types, codes and constant tables for the RAID-6 XOR-code
// bit matrix generator. No dependencies; used by every rtl file of the block.

package raid6xc_pkg;

    localparam int CODE_WIDTH      = 2;
    localparam int K_WIDTH         = 6;
    localparam int W_WIDTH         = 6;
    localparam int IDX_WIDTH       = 5;
    localparam int STATUS_WIDTH    = 2;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 6;

    localparam logic [W_WIDTH-1:0] MAX_WORD_BITS = 6'd32;

    // code kinds
    localparam logic [CODE_WIDTH-1:0] CODE_LIBERATION = 2'd0;
    localparam logic [CODE_WIDTH-1:0] CODE_BLAUM_ROTH = 2'd1;
    localparam logic [CODE_WIDTH-1:0] CODE_LIBER8TION = 2'd2;

    // status codes
    localparam logic [STATUS_WIDTH-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_WIDTH-1:0] STATUS_BAD_WORD  = 2'd1;
    localparam logic [STATUS_WIDTH-1:0] STATUS_TOO_MANY  = 2'd2;
    localparam logic [STATUS_WIDTH-1:0] STATUS_BAD_INDEX = 2'd3;

    // register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_CODE_KIND  = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DATA_DISKS = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_WORD_BITS  = 2'd2;

    // bit n set when n is prime, for n below 64; bits 64 and up are clear
    localparam logic [127:0] PRIME_MASK = 128'h28208A20A08A28AC;

    // liber8tion q part: [disk][row] mask of data bits
    localparam logic [7:0] L8_MASK [8][8] = '{
        '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80},
        '{8'h80, 8'h08, 8'h01, 8'h04, 8'hC0, 8'h02, 8'h20, 8'h10},
        '{8'h40, 8'h0C, 8'h10, 8'h01, 8'h80, 8'h08, 8'h02, 8'h20},
        '{8'h04, 8'h20, 8'h80, 8'h40, 8'h01, 8'h18, 8'h10, 8'h02},
        '{8'h20, 8'h40, 8'h03, 8'h80, 8'h04, 8'h10, 8'h08, 8'h01},
        '{8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h05},
        '{8'h08, 8'h01, 8'h40, 8'h20, 8'h02, 8'h80, 8'h30, 8'h04},
        '{8'h10, 8'h80, 8'h02, 8'h22, 8'h08, 8'h04, 8'h01, 8'h40}
    };

    typedef struct packed {
        logic                 parity_select;
        logic [IDX_WIDTH-1:0] parity_row;
        logic [IDX_WIDTH-1:0] data_disk;
        logic [IDX_WIDTH-1:0] data_bit;
    } in_item_t;

    typedef struct packed {
        logic                    matrix_bit;
        logic [STATUS_WIDTH-1:0] status;
    } out_item_t;

    typedef struct packed {
        logic [CODE_WIDTH-1:0]   code_kind;
        logic [K_WIDTH-1:0]      data_disks;
        logic [W_WIDTH-1:0]      word_bits;
        logic [STATUS_WIDTH-1:0] status;
    } cfg_t;

    function automatic logic is_prime(input logic [6:0] n);
        return PRIME_MASK[n];
    endfunction

    function automatic logic l8_bit(input logic [2:0] d, input logic [2:0] r,
                                    input logic [2:0] b);
        logic [7:0] mask;
        mask = L8_MASK[d][r];
        return mask[b];
    endfunction

endpackage

>>> rtl/raid6xc_cfg_regs.sv
// raid6xc_cfg_regs: configuration registers and the registered configuration
// status (word size and disk count checks). Depends on raid6xc_pkg.

module raid6xc_cfg_regs (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      cfg_wr_en,
    input  logic [raid6xc_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [raid6xc_pkg::CFG_DATA_WIDTH-1:0]    cfg_wdata,
    output raid6xc_pkg::cfg_t                         cfg
);

    logic [raid6xc_pkg::CODE_WIDTH-1:0]   code_kind_reg,  code_kind_next;
    logic [raid6xc_pkg::K_WIDTH-1:0]      data_disks_reg, data_disks_next;
    logic [raid6xc_pkg::W_WIDTH-1:0]      word_bits_reg,  word_bits_next;
    logic [raid6xc_pkg::STATUS_WIDTH-1:0] status_reg,     status_next;
    logic                                 w_ok;

    always_comb begin
        code_kind_next  = code_kind_reg;
        data_disks_next = data_disks_reg;
        word_bits_next  = word_bits_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                raid6xc_pkg::REG_CODE_KIND: begin
                    code_kind_next = cfg_wdata[raid6xc_pkg::CODE_WIDTH-1:0];
                end
                raid6xc_pkg::REG_DATA_DISKS: begin
                    data_disks_next = cfg_wdata[raid6xc_pkg::K_WIDTH-1:0];
                end
                raid6xc_pkg::REG_WORD_BITS: begin
                    word_bits_next = cfg_wdata[raid6xc_pkg::W_WIDTH-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (word_bits_reg < 6'd2 || word_bits_reg > raid6xc_pkg::MAX_WORD_BITS) begin
            w_ok = 1'b0;
        end else begin
            unique case (code_kind_reg)
                raid6xc_pkg::CODE_LIBERATION: begin
                    w_ok = raid6xc_pkg::is_prime({1'b0, word_bits_reg});
                end
                raid6xc_pkg::CODE_BLAUM_ROTH: begin
                    w_ok = raid6xc_pkg::is_prime({1'b0, word_bits_reg} + 7'd1);
                end
                raid6xc_pkg::CODE_LIBER8TION: begin
                    w_ok = (word_bits_reg == 6'd8);
                end
                default: begin
                    w_ok = 1'b0;
                end
            endcase
        end
        if (!w_ok) begin
            status_next = raid6xc_pkg::STATUS_BAD_WORD;
        end else if (data_disks_reg > word_bits_reg) begin
            status_next = raid6xc_pkg::STATUS_TOO_MANY;
        end else begin
            status_next = raid6xc_pkg::STATUS_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            code_kind_reg  <= raid6xc_pkg::CODE_LIBERATION;
            data_disks_reg <= 6'd1;
            word_bits_reg  <= 6'd7;
            status_reg     <= raid6xc_pkg::STATUS_OK;
        end else begin
            code_kind_reg  <= code_kind_next;
            data_disks_reg <= data_disks_next;
            word_bits_reg  <= word_bits_next;
            status_reg     <= status_next;
        end
    end

    assign cfg.code_kind  = code_kind_reg;
    assign cfg.data_disks = data_disks_reg;
    assign cfg.word_bits  = word_bits_reg;
    assign cfg.status     = status_reg;

endmodule

>>> rtl/raid6xc_bit_pipe.sv
// raid6xc_bit_pipe: four-register pipeline that checks indexes and computes one
// bit of the P or Q generator matrix. Depends on raid6xc_pkg.

module raid6xc_bit_pipe (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  raid6xc_pkg::cfg_t      cfg,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  raid6xc_pkg::in_item_t  s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output raid6xc_pkg::out_item_t m_data
);

    typedef struct packed {
        logic                                 sel;
        logic [raid6xc_pkg::CODE_WIDTH-1:0]   code;
        logic [raid6xc_pkg::STATUS_WIDTH-1:0] status;
        logic [raid6xc_pkg::IDX_WIDTH-1:0]    r;
        logic [raid6xc_pkg::IDX_WIDTH-1:0]    d;
        logic [raid6xc_pkg::IDX_WIDTH-1:0]    b;
        logic [raid6xc_pkg::W_WIDTH-1:0]      w;
        logic [5:0]                           lib_sum;
        logic [5:0]                           lib_y;
        logic [6:0]                           br_m0;
        logic [6:0]                           br_alt;
    } st2_t;

    typedef struct packed {
        logic                                 sel;
        logic [raid6xc_pkg::CODE_WIDTH-1:0]   code;
        logic [raid6xc_pkg::STATUS_WIDTH-1:0] status;
        logic                                 p_bit;
        logic                                 br_bit;
        logic                                 l8_bit;
        logic                                 lib_rot_hit;
        logic                                 lib_row_hit;
        logic [6:0]                           lib_t;
        logic [raid6xc_pkg::W_WIDTH-1:0]      w;
        logic [raid6xc_pkg::IDX_WIDTH-1:0]    b;
    } st3_t;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    raid6xc_pkg::in_item_t  s1_reg;
    st2_t                   s2_reg, s2_next;
    st3_t                   s3_reg, s3_next;
    raid6xc_pkg::out_item_t s4_reg, s4_next;

    // stage a locals
    logic [5:0] a_r, a_d, a_b;
    logic       a_idx_bad;
    // stage b locals
    logic [6:0] b_p, b_br_m, b_b7, b_d7;
    logic [5:0] b_lib_rot;
    // stage c locals
    logic [6:0] c_lib_tr;
    logic       c_lib_bit;

    assign rdy4    = !v4_reg || m_ready;
    assign rdy3    = !v3_reg || rdy4;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1;

    // stage a: index checks, rotation sum, liberation row, blaum-roth terms
    always_comb begin
        a_r = {1'b0, s1_reg.parity_row};
        a_d = {1'b0, s1_reg.data_disk};
        a_b = {1'b0, s1_reg.data_bit};
        a_idx_bad = (a_r >= cfg.word_bits) || (a_d >= cfg.data_disks) ||
                    (a_b >= cfg.word_bits);
        s2_next.sel  = s1_reg.parity_select;
        s2_next.code = cfg.code_kind;
        if (cfg.status != raid6xc_pkg::STATUS_OK) begin
            s2_next.status = cfg.status;
        end else if (a_idx_bad) begin
            s2_next.status = raid6xc_pkg::STATUS_BAD_INDEX;
        end else begin
            s2_next.status = raid6xc_pkg::STATUS_OK;
        end
        s2_next.r       = s1_reg.parity_row;
        s2_next.d       = s1_reg.data_disk;
        s2_next.b       = s1_reg.data_bit;
        s2_next.w       = cfg.word_bits;
        s2_next.lib_sum = a_d + a_r;
        // d*(w-1)/2 mod w for odd w
        if (s1_reg.data_disk[0]) begin
            s2_next.lib_y = (cfg.word_bits - a_d) >> 1;
        end else begin
            s2_next.lib_y = cfg.word_bits - (a_d >> 1);
        end
        s2_next.br_m0 = {2'b00, s1_reg.parity_row} + {2'b00, s1_reg.data_disk} + 7'd1;
        if (!s1_reg.data_disk[0]) begin
            s2_next.br_alt = {3'b000, s1_reg.data_disk[4:1]} - 7'd1;
        end else begin
            s2_next.br_alt = (({1'b0, cfg.word_bits} + 7'd1) >> 1) +
                             {3'b000, s1_reg.data_disk[4:1]};
        end
    end

    // stage b: first modular reductions and compares
    always_comb begin
        b_p   = {1'b0, s2_reg.w} + 7'd1;
        b_b7  = {2'b00, s2_reg.b};
        b_d7  = {2'b00, s2_reg.d};
        if (s2_reg.lib_sum >= s2_reg.w) begin
            b_lib_rot = s2_reg.lib_sum - s2_reg.w;
        end else begin
            b_lib_rot = s2_reg.lib_sum;
        end
        if (s2_reg.br_m0 >= b_p) begin
            b_br_m = s2_reg.br_m0 - b_p - 7'd1;
        end else begin
            b_br_m = s2_reg.br_m0 - 7'd1;
        end
        s3_next.sel         = s2_reg.sel;
        s3_next.code        = s2_reg.code;
        s3_next.status      = s2_reg.status;
        s3_next.p_bit       = (s2_reg.b == s2_reg.r);
        s3_next.lib_rot_hit = ({1'b0, s2_reg.b} == b_lib_rot);
        s3_next.lib_row_hit = (s2_reg.d != 5'd0) && ({1'b0, s2_reg.r} == s2_reg.lib_y);
        s3_next.lib_t       = b_d7 + {1'b0, s2_reg.lib_y} - 7'd1;
        s3_next.w           = s2_reg.w;
        s3_next.b           = s2_reg.b;
        if (s2_reg.d == 5'd0) begin
            s3_next.br_bit = (s2_reg.b == s2_reg.r);
        end else if (s2_reg.br_m0 != b_p) begin
            s3_next.br_bit = (b_b7 == b_br_m);
        end else begin
            s3_next.br_bit = (b_b7 == b_d7 - 7'd1) || (b_b7 == s2_reg.br_alt);
        end
        s3_next.l8_bit = raid6xc_pkg::l8_bit(s2_reg.d[2:0], s2_reg.r[2:0], s2_reg.b[2:0]);
    end

    // stage c: extra liberation bit and final select
    always_comb begin
        if (s3_reg.lib_t >= {1'b0, s3_reg.w}) begin
            c_lib_tr = s3_reg.lib_t - {1'b0, s3_reg.w};
        end else begin
            c_lib_tr = s3_reg.lib_t;
        end
        c_lib_bit = s3_reg.lib_rot_hit ||
                    (s3_reg.lib_row_hit && ({2'b00, s3_reg.b} == c_lib_tr));
        s4_next.status = s3_reg.status;
        if (s3_reg.status != raid6xc_pkg::STATUS_OK) begin
            s4_next.matrix_bit = 1'b0;
        end else if (!s3_reg.sel) begin
            s4_next.matrix_bit = s3_reg.p_bit;
        end else if (s3_reg.code == raid6xc_pkg::CODE_LIBERATION) begin
            s4_next.matrix_bit = c_lib_bit;
        end else if (s3_reg.code == raid6xc_pkg::CODE_BLAUM_ROTH) begin
            s4_next.matrix_bit = s3_reg.br_bit;
        end else begin
            s4_next.matrix_bit = s3_reg.l8_bit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= s_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
            if (rdy4) begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            s1_reg <= s_data;
        end
        if (rdy2) begin
            s2_reg <= s2_next;
        end
        if (rdy3) begin
            s3_reg <= s3_next;
        end
        if (rdy4) begin
            s4_reg <= s4_next;
        end
    end

    assign m_valid = v4_reg;
    assign m_data  = s4_reg;

`ifndef SYNTH
    a_error_bit_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (v4_reg && s4_reg.status != raid6xc_pkg::STATUS_OK) |-> !s4_reg.matrix_bit)
        else $error("matrix bit set on an error transaction");

    a_stall_means_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (v1_reg && v2_reg && v3_reg && v4_reg))
        else $error("input stalled while a pipeline stage is empty");

    a_stage_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (v2_reg && rdy3) |=> v3_reg)
        else $error("transaction lost between stages two and three");
`endif

endmodule

>>> rtl/raid6_xor_code_bitmatrix_generator_core.sv
// raid6_xor_code_bitmatrix_generator_core: top level of the RAID-6 XOR-code
// generator bit matrix block. Depends on raid6xc_pkg, raid6xc_cfg_regs, raid6xc_bit_pipe.
// Each transaction is registered through s1_reg, s2_reg, s3_reg and s4_reg to m_data.
// Throughput: one transaction per cycle while m_ready does not stall the pipeline.
// Reset: aresetn synchronous active low; restores code_kind 0, data_disks 1,
// word_bits 7 and empties the pipeline.

module raid6_xor_code_bitmatrix_generator_core (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    cfg_wr_en,
    input  logic [raid6xc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [raid6xc_pkg::CFG_DATA_WIDTH-1:0]  cfg_wdata,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  raid6xc_pkg::in_item_t                   s_data,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output raid6xc_pkg::out_item_t                  m_data
);

    raid6xc_pkg::cfg_t cfg;

    raid6xc_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    raid6xc_bit_pipe u_bit_pipe (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
